@@ hw/rtl/bcla_pkg.sv @@
// bcla_pkg: shared types and constants for the contiguous line allocator
// field widths, operation codes and controller state encoding
// no dependencies
`default_nettype none

package bcla_pkg;

  localparam int OP_W    = 2;
  localparam int LEN_W   = 11;
  localparam int START_W = 10;
  localparam int BASE_W  = 10;
  localparam int FREE_W  = 11;
  localparam int LC_W    = 11;

  localparam logic [LC_W-1:0] LINE_COUNT_RST = 11'd1024;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_COUNT = 7'b0000010,
    S_IDLE  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MARK  = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bitmap_contiguous_line_allocator_core.sv @@
// First-fit contiguous line allocator over a one-bit used/free line map.
// Channels: input transfer (in_op, in_run_length, in_start_line) on in_valid/in_ready,
// one result transfer per item on out_valid/out_ready, and cfg_we/cfg_wdata that
// writes line_count with no wait state. Depends on bcla_pkg.
//
// The used map sits in a single-port-write, single-port-read memory with a
// registered read port; one item is worked at a time by a sequencer that sweeps
// the memory one line per cycle.
// Work per item, from acceptance to result loaded in the output register:
//   query / reserved op : no sweep, straight to the finishing state
//   free                : read and write-back sweep of the managed lines in the range
//   allocate            : scan of the managed lines, then marking of the run from its
//                         base when one fits; a rejected length skips the scan
// The next item can be taken once the result is loaded and the sequencer is idle.
// After reset a clearing pass writes all MAX_LINES lines, then a recount of the
// managed lines runs; in_ready stays low meanwhile.
// Every line_count write starts the same recount, with in_ready low.
// The result register holds while out_ready is low; a new item is still taken
// and waits finished until the held result has been transferred.
`default_nettype none

module bitmap_contiguous_line_allocator_core #(
  parameter int MAX_LINES = 1024
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [bcla_pkg::LC_W-1:0]      cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [bcla_pkg::OP_W-1:0]      in_op,
  input  wire  [bcla_pkg::LEN_W-1:0]     in_run_length,
  input  wire  [bcla_pkg::START_W-1:0]   in_start_line,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_success,
  output logic [bcla_pkg::BASE_W-1:0]    out_found_base,
  output logic [bcla_pkg::FREE_W-1:0]    out_free_lines
);
  import bcla_pkg::*;

  localparam int IW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  // one bit of headroom so start + length never wraps
  localparam int XW = ((CW > LEN_W) ? CW : LEN_W) + 1;

  // line map memory
  logic line_mem [MAX_LINES];
  logic          mem_q_r;
  logic          mem_we, mem_wd, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= line_mem[mem_ra];
  end

  state_t          state_r, state_nxt;
  logic [LC_W-1:0] line_count_r, line_count_nxt;
  logic [CW-1:0]   free_total_r, free_total_nxt;
  logic            recount_r, recount_nxt;
  logic [CW-1:0]   rp_r, rp_nxt;
  logic            rv_r, rv_nxt;
  logic [IW-1:0]   ra_r, ra_nxt;
  logic [CW-1:0]   acc_r, acc_nxt;
  logic [IW-1:0]   base_r, base_nxt;
  logic [CW-1:0]   end_r, end_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic            ok_r, ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_success_r, out_success_nxt;
  logic [BASE_W-1:0] out_base_r, out_base_nxt;
  logic [FREE_W-1:0] out_free_r, out_free_nxt;

  logic [CW-1:0] eff;
  logic [XW-1:0] lc_x, eff_x, len_x, start_x, fend_x, run_nxt_x, base_x, ft_x;
  logic          in_xfer;

  // line_count clamped to 1..MAX_LINES
  always_comb begin
    lc_x = XW'(line_count_r);
    if (lc_x == '0)
      eff = CW'(1);
    else if (lc_x > XW'(MAX_LINES))
      eff = CW'(MAX_LINES);
    else
      eff = lc_x[CW-1:0];
  end

  assign eff_x    = XW'(eff);
  assign in_ready = (state_r == S_IDLE) && !recount_r && !cfg_we;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    line_count_nxt  = cfg_we ? cfg_wdata : line_count_r;
    free_total_nxt  = free_total_r;
    recount_nxt     = (cfg_we || recount_r) && (state_r != S_COUNT);
    rp_nxt          = rp_r;
    rv_nxt          = 1'b0;
    ra_nxt          = ra_r;
    acc_nxt         = acc_r;
    base_nxt        = base_r;
    end_nxt         = end_r;
    op_nxt          = op_r;
    len_nxt         = len_r;
    ok_nxt          = ok_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_success_nxt = out_success_r;
    out_base_nxt    = out_base_r;
    out_free_nxt    = out_free_r;
    mem_we          = 1'b0;
    mem_wd          = 1'b0;
    mem_wa          = rp_r[IW-1:0];
    mem_re          = 1'b0;
    mem_ra          = rp_r[IW-1:0];
    len_x           = XW'(in_run_length);
    start_x         = XW'(in_start_line);
    fend_x          = start_x + len_x;
    if (fend_x > eff_x) fend_x = eff_x;
    run_nxt_x       = XW'(acc_r) + XW'(1);
    base_x          = XW'(base_r);
    ft_x            = XW'(free_total_r);

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        rp_nxt = rp_r + CW'(1);
        if (rp_r == CW'(MAX_LINES - 1)) begin
          state_nxt = S_COUNT;
          rp_nxt    = '0;
          acc_nxt   = '0;
        end
      end

      S_COUNT: begin
        if (rp_r < eff) begin
          mem_re = 1'b1;
          rp_nxt = rp_r + CW'(1);
          rv_nxt = 1'b1;
          ra_nxt = rp_r[IW-1:0];
        end
        if (rv_r && !mem_q_r) acc_nxt = acc_r + CW'(1);
        if (rp_r >= eff && !rv_r) begin
          free_total_nxt = acc_r;
          state_nxt      = S_IDLE;
        end
        // a register write mid-sweep restarts the count
        if (cfg_we) begin
          state_nxt = S_COUNT;
          rp_nxt    = '0;
          acc_nxt   = '0;
          rv_nxt    = 1'b0;
        end
      end

      S_IDLE: begin
        rp_nxt  = '0;
        acc_nxt = '0;
        if (recount_r) begin
          state_nxt = S_COUNT;
        end else if (in_xfer) begin
          op_nxt   = in_op;
          len_nxt  = in_run_length;
          base_nxt = '0;
          ok_nxt   = 1'b0;
          state_nxt = S_DONE;
          if (in_op == OP_ALLOC) begin
            if (in_run_length != '0 && len_x <= eff_x) begin
              state_nxt = S_SCAN;
              end_nxt   = eff;
            end
          end else if (in_op == OP_FREE) begin
            ok_nxt = 1'b1;
            if (start_x < fend_x) begin
              state_nxt = S_FREE;
              rp_nxt    = start_x[CW-1:0];
              end_nxt   = fend_x[CW-1:0];
            end
          end
        end
      end

      S_SCAN: begin
        if (rp_r < end_r) begin
          mem_re = 1'b1;
          rp_nxt = rp_r + CW'(1);
          rv_nxt = 1'b1;
          ra_nxt = rp_r[IW-1:0];
        end
        if (rv_r) begin
          if (!mem_q_r) begin
            if (acc_r == '0) base_nxt = ra_r;
            acc_nxt = acc_r + CW'(1);
            if (run_nxt_x == XW'(len_r)) begin
              // run found: mark it from its base
              state_nxt = S_MARK;
              rp_nxt    = (acc_r == '0) ? CW'(ra_r) : CW'(base_r);
              rv_nxt    = 1'b0;
            end
          end else begin
            acc_nxt = '0;
          end
        end else if (rp_r >= end_r) begin
          ok_nxt    = 1'b0;
          base_nxt  = '0;
          state_nxt = S_DONE;
        end
      end

      S_MARK: begin
        mem_we  = 1'b1;
        mem_wd  = 1'b1;
        rp_nxt  = rp_r + CW'(1);
        acc_nxt = acc_r - CW'(1);
        if (acc_r == CW'(1)) begin
          free_total_nxt = free_total_r - CW'(len_r);
          ok_nxt         = 1'b1;
          state_nxt      = S_DONE;
        end
      end

      S_FREE: begin
        if (rp_r < end_r) begin
          mem_re = 1'b1;
          rp_nxt = rp_r + CW'(1);
          rv_nxt = 1'b1;
          ra_nxt = rp_r[IW-1:0];
        end
        // write back the line whose read just returned
        if (rv_r) begin
          mem_we = 1'b1;
          mem_wa = ra_r;
          if (mem_q_r) acc_nxt = acc_r + CW'(1);
        end else if (rp_r >= end_r) begin
          free_total_nxt = free_total_r + acc_r;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = (op_r == OP_QUERY) ? (ft_x > XW'(len_r)) : ok_r;
          out_base_nxt    = base_x[BASE_W-1:0];
          out_free_nxt    = ft_x[FREE_W-1:0];
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      line_count_r <= LINE_COUNT_RST;
      free_total_r <= '0;
      recount_r    <= 1'b0;
      rp_r         <= '0;
      rv_r         <= 1'b0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_count_r <= line_count_nxt;
      free_total_r <= free_total_nxt;
      recount_r    <= recount_nxt;
      rp_r         <= rp_nxt;
      rv_r         <= rv_nxt;
      acc_r        <= acc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r          <= ra_nxt;
    base_r        <= base_nxt;
    end_r         <= end_nxt;
    op_r          <= op_nxt;
    len_r         <= len_nxt;
    ok_r          <= ok_nxt;
    out_success_r <= out_success_nxt;
    out_base_r    <= out_base_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_success    = out_success_r;
  assign out_found_base = out_base_r;
  assign out_free_lines = out_free_r;

  // free count never exceeds the managed lines once settled
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !recount_r) |-> (free_total_r <= eff))
    else $error("free count above managed line count");

  // marking stays inside the managed lines
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (rp_r < eff && acc_r != '0))
    else $error("run marking out of range");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("accepted item not started");

  // a result is only loaded from the finishing state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside finish");

endmodule

`default_nettype wire

@@ bench/tb_bitmap_contiguous_line_allocator_core.sv @@
// Self-checking bench for bitmap_contiguous_line_allocator_core: directed and random allocate,
// free and query traffic across several line counts, with handshake stalls on both channels.
// Depends on bcla_pkg and the allocator core RTL.

module tb_bitmap_contiguous_line_allocator_core;
  import bcla_pkg::*;

  localparam int LINES = 1024;
  localparam int unsigned LIMIT = 6000000;
  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

  typedef struct {
    logic              success;
    logic [BASE_W-1:0] found_base;
    logic [FREE_W-1:0] free_lines;
  } alloc_result_t;

  // mirror of the line map, free count and line count register
  class line_alloc_scoreboard;
    bit            used_map [LINES];
    int unsigned   line_count_reg;
    int unsigned   free_count;
    alloc_result_t expected_q [$];
    int unsigned   run_base_q [$];
    int unsigned   run_len_q [$];
    int            errors;
    int            items_seen;
    int            results_seen;
    int            alloc_hits;
    int            alloc_misses;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      line_count_reg = LINE_COUNT_RST;
      errors = 0;
      items_seen = 0;
      results_seen = 0;
      alloc_hits = 0;
      alloc_misses = 0;
      recount();
    endfunction

    function int unsigned managed();
      int unsigned n;
      n = line_count_reg;
      if (n == 0) n = 1;
      if (n > LINES) n = LINES;
      return n;
    endfunction

    function void recount();
      int unsigned n;
      int unsigned i;
      n = managed();
      free_count = 0;
      for (i = 0; i < n; i++)
        if (!used_map[i]) free_count++;
    endfunction

    function void set_line_count(logic [LC_W-1:0] value);
      line_count_reg = value;
      recount();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                            logic [START_W-1:0] start);
      int unsigned   n;
      int unsigned   run;
      int unsigned   base;
      int unsigned   stop;
      int unsigned   i;
      bit            found;
      alloc_result_t r;
      n = managed();
      r.success = 1'b0;
      r.found_base = '0;
      found = 1'b0;
      run = 0;
      base = 0;
      case (op)
        OP_ALLOC: begin
          if (len != 0 && len <= n) begin
            // first fit: stop at the first free run that reaches the length
            for (i = 0; i < n && !found; i++) begin
              if (!used_map[i]) begin
                if (run == 0) base = i;
                run++;
                if (run == len) found = 1'b1;
              end else begin
                run = 0;
              end
            end
          end
          if (found) begin
            for (i = base; i < base + len; i++) used_map[i] = 1'b1;
            r.success = 1'b1;
            r.found_base = base[BASE_W-1:0];
            run_base_q.push_back(base);
            run_len_q.push_back(len);
            alloc_hits++;
          end else begin
            alloc_misses++;
          end
        end
        OP_FREE: begin
          stop = start + len;
          if (stop > n) stop = n;
          for (i = start; i < stop; i++) used_map[i] = 1'b0;
          r.success = 1'b1;
        end
        default: ;
      endcase
      recount();
      if (op == OP_QUERY) r.success = (free_count > len);
      r.free_lines = free_count[FREE_W-1:0];
      expected_q.push_back(r);
      items_seen++;
    endfunction

    function void check_result(logic success, logic [BASE_W-1:0] found_base,
                               logic [FREE_W-1:0] free_lines);
      alloc_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: success %0d base %0d free %0d",
                 $time, success, found_base, free_lines);
        return;
      end
      e = expected_q.pop_front();
      if (success !== e.success) begin
        errors++;
        $display("%0t: success expected %0d got %0d", $time, e.success, success);
      end
      if (found_base !== e.found_base) begin
        errors++;
        $display("%0t: found_base expected %0d got %0d", $time, e.found_base, found_base);
      end
      if (free_lines !== e.free_lines) begin
        errors++;
        $display("%0t: free_lines expected %0d got %0d", $time, e.free_lines, free_lines);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [LC_W-1:0]     cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = '0;
  logic [LEN_W-1:0]    in_run_length = '0;
  logic [START_W-1:0]  in_start_line = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_success;
  logic [BASE_W-1:0]   out_found_base;
  logic [FREE_W-1:0]   out_free_lines;

  line_alloc_scoreboard sb;
  bit                   fast_phase = 1'b0;
  int unsigned          cycles = 0;
  int                   lc_writes = 0;

  bitmap_contiguous_line_allocator_core #(
    .MAX_LINES(LINES)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_run_length (in_run_length),
    .in_start_line (in_start_line),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_success   (out_success),
    .out_found_base(out_found_base),
    .out_free_lines(out_free_lines)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_line_count(cfg_wdata);
      if (in_valid && in_ready) sb.note_item(in_op, in_run_length, in_start_line);
      if (out_valid && out_ready) sb.check_result(out_success, out_found_base, out_free_lines);
    end
  end

  // result side: short random stalls, two long hold-offs to back the block up
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 150 || taken == 420) stall = 300;
      else stall = fast_phase ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // valid stays up between back-to-back items, so it is only lowered for a gap
  task automatic send_item(logic [OP_W-1:0] op, int unsigned len, int unsigned start);
    int unsigned gap;
    gap = fast_phase ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_run_length <= len[LEN_W-1:0];
    in_start_line <= start[START_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every outstanding result, then for the block to sit idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_line_count(int unsigned value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[LC_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    lc_writes++;
  endtask

  task automatic random_item();
    int unsigned r;
    int unsigned k;
    int unsigned n;
    int unsigned len;
    int unsigned start;
    int unsigned idx;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    n = sb.managed();
    if (r < 50) begin
      if (k < 3) len = 0;
      else if (k < 6) len = $urandom_range(0, LINES);
      else if (k < 14) len = $urandom_range(1, n);
      else len = $urandom_range(1, n < 24 ? n : 24);
      send_item(OP_ALLOC, len, $urandom_range(0, LINES - 1));
    end else if (r < 85) begin
      if (k < 60 && sb.run_base_q.size() != 0) begin
        // release a run handed out earlier
        idx = $urandom_range(0, sb.run_base_q.size() - 1);
        start = sb.run_base_q[idx];
        len = sb.run_len_q[idx];
        sb.run_base_q.delete(idx);
        sb.run_len_q.delete(idx);
      end else if (k < 92) begin
        start = $urandom_range(0, n - 1);
        len = $urandom_range(0, 16);
      end else begin
        start = $urandom_range(0, LINES - 1);
        len = $urandom_range(0, LINES);
      end
      send_item(OP_FREE, len, start);
    end else if (r < 97) begin
      send_item(OP_QUERY, $urandom_range(0, n + 1), $urandom_range(0, LINES - 1));
    end else begin
      send_item(OP_RSVD, $urandom_range(0, LINES), $urandom_range(0, LINES - 1));
    end
  endtask

  task automatic run_phase(int unsigned line_count, int count, bit no_gaps);
    write_line_count(line_count);
    fast_phase = no_gaps;
    // start each phase from an empty map
    send_item(OP_FREE, LINES, 0);
    sb.run_base_q.delete();
    sb.run_len_q.delete();
    repeat (count) random_item();
    fast_phase = 1'b0;
  endtask

  task automatic directed_items();
    send_item(OP_ALLOC, 0, 0);          // zero length refused
    send_item(OP_ALLOC, 1, 1023);
    send_item(OP_ALLOC, LINES, 0);      // longer than the free space
    send_item(OP_QUERY, 1023, 0);
    send_item(OP_QUERY, 1022, 0);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_FREE, 1, 0);
    send_item(OP_ALLOC, LINES, 0);      // whole map
    send_item(OP_ALLOC, 1, 0);          // nothing left
    send_item(OP_QUERY, 0, 0);
    send_item(OP_FREE, LINES, 1000);    // range runs off the end
    send_item(OP_FREE, 1, 1023);        // already free
    send_item(OP_RSVD, 5, 513);
    send_item(OP_FREE, 0, 0);
    send_item(OP_ALLOC, 24, 0);
    send_item(OP_FREE, 512, 512);
    send_item(OP_ALLOC, 3, 0);
    write_line_count(8);
    send_item(OP_FREE, 30, 600);        // above the managed lines
    send_item(OP_FREE, 3, 2);
    send_item(OP_ALLOC, 4, 0);          // hole too short
    send_item(OP_ALLOC, 3, 0);
    send_item(OP_ALLOC, 9, 0);          // longer than the line count
    write_line_count(0);                // acts as one line
    send_item(OP_FREE, 1, 0);
    send_item(OP_ALLOC, 1, 0);
    write_line_count(2047);             // clamps, old bits above count again
    send_item(OP_QUERY, 500, 0);
    send_item(OP_QUERY, LINES, 0);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    run_phase(LINES, 70, 1'b0);
    run_phase(64, 130, 1'b0);
    run_phase(200, 110, 1'b1);
    run_phase(16, 100, 1'b0);
    run_phase(2047, 50, 1'b0);
    run_phase(1, 30, 1'b0);
    run_phase($urandom_range(100, 400), 60, 1'b0);
    settle();
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked; %0d allocations placed, %0d refused",
             sb.items_seen, sb.results_seen, sb.alloc_hits, sb.alloc_misses);
    $display("line count written %0d times, clamped extremes included, over %0d cycles",
             lc_writes, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
